### sv/fbpa_pkg.sv
`timescale 1ns / 1ps
package fbpa_pkg;

    localparam int ADDR_W      = 18;
    localparam int UNITS_W     = 10;
    localparam int ADDR_UNIT_W = ADDR_W - 6;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    localparam logic REG_BLOCK_UNITS = 1'b0;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_NULL
    } kind_t;

    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_FREED   = 3'd1,
        ST_NULL    = 3'd2,
        ST_FOREIGN = 3'd3,
        ST_DOUBLE  = 3'd4,
        ST_OOM     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DIVEND,
        S_DISPATCH,
        S_CLAIM_BASE,
        S_CLAIM,
        S_POP_RD,
        S_POP_WR,
        S_LOC,
        S_MUL,
        S_FCH,
        S_FCHECK,
        S_FIDX,
        S_FRD,
        S_FUPD,
        S_DONE
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } res_t;

    typedef struct packed {
        logic [UNITS_W-1:0] units;
        logic               wr;
    } cfg_t;

endpackage

### sv/fbpa_front.sv
`timescale 1ns / 1ps
module fbpa_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [fbpa_pkg::ADDR_W-1:0] addr,
    input  logic                  cmd,
    input  logic                  is_null,
    output logic                  q_valid,
    input  logic                  q_ready,
    output fbpa_pkg::item_t       q_item
);
    import fbpa_pkg::*;

    item_t       fifo_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;
    item_t       cls;

    always_comb
    begin
        cls.addr = addr;
        if (!cmd)
            cls.kind = K_ALLOC;
        else if (is_null)
            cls.kind = K_NULL;
        else
            cls.kind = K_FREE;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### sv/fbpa_engine.sv
`timescale 1ns / 1ps
module fbpa_engine
#(
    parameter int CHUNK_BYTES = 65536,
    parameter int NUM_CHUNKS  = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  fbpa_pkg::cfg_t  cfg,
    output logic            any_claimed,
    input  logic            q_valid,
    output logic            q_ready,
    input  fbpa_pkg::item_t q_item,
    output logic            res_valid,
    input  logic            res_ready,
    output fbpa_pkg::res_t  res
);
    import fbpa_pkg::*;

    localparam int Q        = CHUNK_BYTES / 64 - 1;
    localparam int SW       = $clog2(Q + 1);
    localparam int SLOT_CAP = NUM_CHUNKS * Q;
    localparam int IW       = $clog2(SLOT_CAP + 1);
    localparam int AW       = $clog2(SLOT_CAP);
    localparam int CW       = $clog2(NUM_CHUNKS + 1);
    localparam int DVW      = (SW > ADDR_UNIT_W) ? SW : ADDR_UNIT_W;
    localparam int DCW      = $clog2(DVW + 1);
    localparam logic [IW-1:0]     NO_SLOT = IW'(SLOT_CAP);
    localparam logic [20:0]       CB21    = 21'(CHUNK_BYTES);
    localparam logic [20:0]       TAIL21  = 21'(CHUNK_BYTES - 64);
    localparam logic [ADDR_W-1:0] CB18    = ADDR_W'(CHUNK_BYTES);

    logic [IW:0] mem [SLOT_CAP];
    logic [IW:0] rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [IW:0] mem_wd;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [IW-1:0]      head_reg, head_next;
    logic               hv_reg, hv_next;
    logic [CW-1:0]      claimed_reg, claimed_next;
    logic [SW-1:0]      s_reg, s_next;
    logic               sv_reg, sv_next;
    logic [IW-1:0]      base_reg, base_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [CW-1:0]      ch_reg, ch_next;
    logic [ADDR_W-1:0]  acc_reg, acc_next;
    logic [UNITS_W-1:0] rem_reg, rem_next;
    logic [DVW-1:0]     quo_reg, quo_next;
    logic [DVW-1:0]     dvd_reg, dvd_next;
    logic [DCW-1:0]     dcnt_reg, dcnt_next;
    logic               geo_reg, geo_next;
    res_t               res_reg, res_next;

    logic [UNITS_W-1:0] u;
    logic [UNITS_W:0]   t;
    logic               ge;
    logic [IW-1:0]      widx;
    logic [SW+UNITS_W-1:0] prod;

    assign u           = (cfg.units == '0) ? UNITS_W'(1) : cfg.units;
    assign any_claimed = (claimed_reg != '0);
    assign res         = res_reg;
    assign t           = {rem_reg, dvd_reg[DVW-1]};
    assign ge          = (t >= {1'b0, u});
    assign widx        = base_reg + IW'(cnt_reg);
    assign prod        = base_reg[SW-1:0] * u;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        head_next    = head_reg;
        hv_next      = hv_reg;
        claimed_next = claimed_reg;
        s_next       = s_reg;
        sv_next      = sv_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        off_next     = off_reg;
        ch_next      = ch_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvd_next     = dvd_reg;
        dcnt_next    = dcnt_reg;
        geo_next     = geo_reg;
        res_next     = res_reg;
        q_ready      = 1'b0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = base_reg[AW-1:0];
        mem_wd       = '0;
        mem_ra       = head_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready   = 1'b1;
                    item_next = q_item;
                    if (q_item.kind == K_NULL)
                    begin
                        res_next   = '{addr: '0, status: ST_NULL};
                        state_next = S_DONE;
                    end
                    else if (!sv_reg)
                    begin
                        geo_next   = 1'b1;
                        dvd_next   = DVW'(Q);
                        rem_next   = '0;
                        quo_next   = '0;
                        dcnt_next  = '0;
                        state_next = S_DIV;
                    end
                    else
                        state_next = S_DISPATCH;
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? UNITS_W'(t - {1'b0, u}) : t[UNITS_W-1:0];
                quo_next  = {quo_reg[DVW-2:0], ge};
                dvd_next  = dvd_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(DVW - 1))
                    state_next = S_DIVEND;
            end
            S_DIVEND:
            begin
                if (geo_reg)
                begin
                    geo_next   = 1'b0;
                    s_next     = SW'(quo_reg);
                    sv_next    = 1'b1;
                    state_next = S_DISPATCH;
                end
                else if (rem_reg != '0 || quo_reg >= DVW'(s_reg))
                begin
                    res_next   = '{addr: '0, status: ST_FOREIGN};
                    state_next = S_DONE;
                end
                else
                    state_next = S_FIDX;
            end
            S_DISPATCH:
            begin
                if (item_reg.kind == K_FREE)
                begin
                    off_next   = item_reg.addr;
                    ch_next    = '0;
                    state_next = S_FCH;
                end
                else if (hv_reg)
                    state_next = S_POP_RD;
                else if (s_reg == '0 || claimed_reg == CW'(NUM_CHUNKS))
                begin
                    res_next   = '{addr: '0, status: ST_OOM};
                    state_next = S_DONE;
                end
                else
                    state_next = S_CLAIM_BASE;
            end
            S_CLAIM_BASE:
            begin
                base_next  = IW'(claimed_reg) * IW'(s_reg);
                cnt_next   = '0;
                state_next = S_CLAIM;
            end
            S_CLAIM:
            begin
                mem_we = 1'b1;
                mem_wa = widx[AW-1:0];
                if (cnt_reg + 1'b1 == s_reg)
                begin
                    mem_wd       = {1'b0, NO_SLOT};
                    head_next    = base_reg;
                    hv_next      = 1'b1;
                    claimed_next = claimed_reg + 1'b1;
                    state_next   = S_POP_RD;
                end
                else
                begin
                    mem_wd   = {1'b0, widx + 1'b1};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_POP_RD:
            begin
                mem_ra     = head_reg[AW-1:0];
                state_next = S_POP_WR;
            end
            S_POP_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = head_reg[AW-1:0];
                mem_wd     = {1'b1, rd_data_reg[IW-1:0]};
                base_next  = head_reg;
                head_next  = rd_data_reg[IW-1:0];
                hv_next    = (rd_data_reg[IW-1:0] < NO_SLOT);
                acc_next   = '0;
                state_next = S_LOC;
            end
            S_LOC:
            begin
                if (base_reg >= IW'(s_reg))
                begin
                    base_next = base_reg - IW'(s_reg);
                    acc_next  = acc_reg + CB18;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                res_next   = '{addr: acc_reg + ADDR_W'({prod, 6'b0}), status: ST_ALLOC};
                state_next = S_DONE;
            end
            S_FCH:
            begin
                if (ch_reg == claimed_reg)
                begin
                    res_next   = '{addr: '0, status: ST_FOREIGN};
                    state_next = S_DONE;
                end
                else if ({3'b0, off_reg} >= CB21)
                begin
                    off_next = off_reg - CB21[ADDR_W-1:0];
                    ch_next  = ch_reg + 1'b1;
                end
                else
                    state_next = S_FCHECK;
            end
            S_FCHECK:
            begin
                if (s_reg == '0 || off_reg[5:0] != 6'd0 || {3'b0, off_reg} >= TAIL21)
                begin
                    res_next   = '{addr: '0, status: ST_FOREIGN};
                    state_next = S_DONE;
                end
                else
                begin
                    geo_next   = 1'b0;
                    dvd_next   = DVW'(off_reg[ADDR_W-1:6]);
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_FIDX:
            begin
                base_next  = IW'(ch_reg) * IW'(s_reg) + IW'(quo_reg);
                state_next = S_FRD;
            end
            S_FRD:
            begin
                mem_ra     = base_reg[AW-1:0];
                state_next = S_FUPD;
            end
            S_FUPD:
            begin
                if (!rd_data_reg[IW])
                    res_next = '{addr: '0, status: ST_DOUBLE};
                else
                begin
                    mem_we    = 1'b1;
                    mem_wa    = base_reg[AW-1:0];
                    mem_wd    = {1'b0, hv_reg ? head_reg : NO_SLOT};
                    head_next = base_reg;
                    hv_next   = 1'b1;
                    res_next  = '{addr: '0, status: ST_FREED};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.wr)
            sv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hv_reg      <= 1'b0;
            head_reg    <= '0;
            claimed_reg <= '0;
            sv_reg      <= 1'b0;
            geo_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hv_reg      <= hv_next;
            head_reg    <= head_next;
            claimed_reg <= claimed_next;
            sv_reg      <= sv_next;
            geo_reg     <= geo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        s_reg    <= s_next;
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        off_reg  <= off_next;
        ch_reg   <= ch_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvd_reg  <= dvd_next;
        dcnt_reg <= dcnt_next;
        res_reg  <= res_next;
    end

endmodule

### sv/fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// channel | dir | tdata                  | tuser
// s       | in  | [17:0] free_addr       | [0] cmd, [1] free_is_null
// m       | out | [17:0] block_addr      | [2:0] status
// apb     | in  | block_units at 0x0, 10 bits, ignored once a chunk is claimed
// Alloc from the free list: a link-memory read and write, then a slot-to-chunk walk
// and a multiply. Alloc that claims a chunk first writes one link per slot of the chunk.
// Free: a walk over the claimed chunks to find it, then the shared 12-step divider, then
// a read and a write of the link memory; null frees answer straight from the queue.
// First non-null item after reset or a block_units write adds one divider pass.
// No clearing pass after reset; a 2-deep request queue and the output register
// decouple both sides.
module fixed_block_pool_allocator_unit
#(
    parameter int CHUNK_BYTES = 65536,
    parameter int NUM_CHUNKS  = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] free_addr, rest zero
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] free_is_null
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [17:0] block_addr, rest zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fbpa_pkg::*;

    logic [UNITS_W-1:0] units_reg;
    logic               any_claimed;
    logic               reg_wr;
    cfg_t               cfg;
    logic               q_valid;
    logic               q_ready;
    item_t              q_item;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               out_valid_reg;
    res_t               out_reg;

    assign pready = 1'b1;
    assign prdata = {22'b0, units_reg};
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCK_UNITS)
                    && !any_claimed;
    assign cfg    = '{units: units_reg, wr: reg_wr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            units_reg <= UNITS_W'(1);
        else if (reg_wr)
            units_reg <= pwdata[UNITS_W-1:0];
    end

    fbpa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .addr    (s_tdata[ADDR_W-1:0]),
        .cmd     (s_tuser[0]),
        .is_null (s_tuser[1]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    fbpa_engine #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .any_claimed(any_claimed),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.addr};
    assign m_tuser  = out_reg.status;

endmodule

### sv/fbpa_checker.sv
`timescale 1ns / 1ps
module fbpa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import fbpa_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_OOM)
        else $error("status code out of range");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_ALLOC |-> m_tdata == 24'd0)
        else $error("nonzero address on non-alloc result");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_ALLOC |-> m_tdata[5:0] == 6'd0)
        else $error("allocated block not 64-byte aligned");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
